FILE: src/sps_pkg.sv
// Shared types and constants of the stimulation phase sequencer.
// No dependencies; imported by sps_regs and stimulation_phase_sequencer.
`timescale 1ns / 1ps

package sps_pkg;

  // Ticks in one tenth unit of the hold and relax lengths
  localparam int unsigned TENTH_TICKS = 10;

  localparam int unsigned CFG_WIDTH   = 8;
  localparam int unsigned LIMIT_WIDTH = 12;  // holds 255 * 10
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  typedef enum logic [2:0] {
    PH_OFF   = 3'd0,
    PH_RISE  = 3'd1,
    PH_HOLD  = 3'd2,
    PH_FALL  = 3'd3,
    PH_CHAN  = 3'd4,
    PH_RELAX = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ZERO      = 3'd1,
    CMD_LOAD_RISE = 3'd2,
    CMD_RISE      = 3'd3,
    CMD_HOLD      = 3'd4,
    CMD_LOAD_FALL = 3'd5,
    CMD_FALL      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_RAMP_UP    = 3'd0,
    REG_HOLD       = 3'd1,
    REG_RAMP_DOWN  = 3'd2,
    REG_CHAN_STEPS = 3'd3,
    REG_RELAX      = 3'd4,
    REG_CYC_BANK   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] ramp_up_ticks;
    logic [CFG_WIDTH-1:0] hold_tenths;
    logic [CFG_WIDTH-1:0] ramp_down_ticks;
    logic [CFG_WIDTH-1:0] channel_steps;
    logic [CFG_WIDTH-1:0] relax_tenths;
    logic [CFG_WIDTH-1:0] cycles_per_bank;
  } cfg_t;

  // Scale a tenths setting to ticks: x*10 = x*8 + x*2
  function automatic logic [LIMIT_WIDTH-1:0] tenths_to_ticks(input logic [CFG_WIDTH-1:0] x);
    logic [LIMIT_WIDTH-1:0] xe;
    xe = LIMIT_WIDTH'(x);
    return (xe << 3) + (xe << 1);
  endfunction

endpackage

FILE: src/sps_regs.sv
// APB configuration register file of the stimulation phase sequencer.
// Depends on sps_pkg for the register index codes and the cfg_t bundle.
`timescale 1ns / 1ps

module sps_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::APB_AW-1:0]  paddr,
  input  logic [sps_pkg::APB_DW-1:0]  pwdata,
  output logic [sps_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output sps_pkg::cfg_t               cfg
);
  import sps_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_up_ticks   <= CFG_WIDTH'(10);
      cfg.hold_tenths     <= CFG_WIDTH'(5);
      cfg.ramp_down_ticks <= CFG_WIDTH'(10);
      cfg.channel_steps   <= '0;
      cfg.relax_tenths    <= CFG_WIDTH'(5);
      cfg.cycles_per_bank <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_RAMP_UP:    cfg.ramp_up_ticks   <= pwdata[CFG_WIDTH-1:0];
        REG_HOLD:       cfg.hold_tenths     <= pwdata[CFG_WIDTH-1:0];
        REG_RAMP_DOWN:  cfg.ramp_down_ticks <= pwdata[CFG_WIDTH-1:0];
        REG_CHAN_STEPS: cfg.channel_steps   <= pwdata[CFG_WIDTH-1:0];
        REG_RELAX:      cfg.relax_tenths    <= pwdata[CFG_WIDTH-1:0];
        REG_CYC_BANK:   cfg.cycles_per_bank <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RAMP_UP:    prdata = APB_DW'(cfg.ramp_up_ticks);
      REG_HOLD:       prdata = APB_DW'(cfg.hold_tenths);
      REG_RAMP_DOWN:  prdata = APB_DW'(cfg.ramp_down_ticks);
      REG_CHAN_STEPS: prdata = APB_DW'(cfg.channel_steps);
      REG_RELAX:      prdata = APB_DW'(cfg.relax_tenths);
      REG_CYC_BANK:   prdata = APB_DW'(cfg.cycles_per_bank);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: src/stimulation_phase_sequencer.sv
// Top level of the stimulation phase sequencer: phase machine and result register.
// Depends on sps_pkg and instantiates sps_regs.
`timescale 1ns / 1ps

// Stimulation phase sequencer. Each transfer on the slave stream (tick, start
// or stop in s_tuser, channel-wrap flag in s_tdata) steps a six-phase machine
// (off, ramp up, hold, ramp down, channel step, relax) and produces exactly one
// transfer on the master stream with the phase after the step, the last power
// command issued in that step, the bank in use and two strobes. The step is
// resolved in the cycle of acceptance and lands in the result register, so a
// result appears in the cycle after its input and the block takes one transfer
// per cycle; the only thing that stalls input is a full result register whose
// transfer is not taken that cycle. Hold and relax lengths are programmed in
// tenths (ten ticks each); a zero hold or zero channel count runs forever and
// a zero cycles_per_bank never toggles the bank. Write the APB registers only
// while the stream is idle.
module stimulation_phase_sequencer #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [0] channel_wrapped, [7:1] zero
  input  logic [1:0]                  s_tuser,   // [1:0] action
  // master stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [2:0] phase, [5:3] power_command,
                                                 // [6] bank, [7] bank_toggled,
                                                 // [8] advance_channel, [15:9] zero
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::APB_AW-1:0]  paddr,
  input  logic [sps_pkg::APB_DW-1:0]  pwdata,
  output logic [sps_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import sps_pkg::*;

  cfg_t cfg;

  // machine state
  phase_t                 phase_reg, phase_reg_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [CFG_WIDTH-1:0]   channel_count, channel_count_next;
  logic [CFG_WIDTH-1:0]   cycle_count, cycle_count_next;
  logic                   bank_reg, bank_reg_next;

  // step results
  cmd_t cmd_next;
  logic toggled_next;
  logic advanced_next;

  // result register
  phase_t out_phase;
  cmd_t   out_cmd;
  logic   out_bank;
  logic   out_toggled;
  logic   out_advanced;

  logic                   accept;
  action_t                action;
  logic                   wrapped;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [CFG_WIDTH-1:0]   chan_inc;
  logic [CFG_WIDTH-1:0]   cycle_inc;
  logic [COUNT_WIDTH-1:0] hold_limit;
  logic [COUNT_WIDTH-1:0] relax_limit;

  sps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take a new transfer whenever the result register is empty or drains now.
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign action   = action_t'(s_tuser);
  assign wrapped  = s_tdata[0];

  // Counters wrap at their widths.
  assign tick_inc    = tick_count + COUNT_WIDTH'(1);
  assign chan_inc    = channel_count + CFG_WIDTH'(1);
  assign cycle_inc   = cycle_count + CFG_WIDTH'(1);
  assign hold_limit  = COUNT_WIDTH'(tenths_to_ticks(cfg.hold_tenths));
  assign relax_limit = COUNT_WIDTH'(tenths_to_ticks(cfg.relax_tenths));

  // Resolve one step. A phase change runs the entry action of the new phase
  // within the same step; only the last command survives.
  always_comb begin
    phase_reg_next     = phase_reg;
    tick_count_next    = tick_count;
    channel_count_next = channel_count;
    cycle_count_next   = cycle_count;
    bank_reg_next      = bank_reg;
    cmd_next           = CMD_NONE;
    toggled_next       = 1'b0;
    advanced_next      = 1'b0;

    if (phase_reg == PH_OFF || phase_reg > PH_RELAX) begin
      phase_reg_next = PH_OFF;
      if (action == ACT_START) begin
        // start from off: clear everything, bank back to zero without a strobe
        bank_reg_next      = 1'b0;
        tick_count_next    = '0;
        cycle_count_next   = '0;
        channel_count_next = '0;
        cmd_next           = CMD_LOAD_RISE;
        phase_reg_next     = PH_RISE;
      end
    end else if (action == ACT_STOP) begin
      cmd_next       = CMD_ZERO;
      phase_reg_next = PH_OFF;
    end else if (action == ACT_TICK) begin
      case (phase_reg)
        PH_RISE: begin
          if (tick_inc >= COUNT_WIDTH'(cfg.ramp_up_ticks)) begin
            tick_count_next = '0;
            cmd_next        = CMD_HOLD;
            phase_reg_next  = PH_HOLD;
          end else begin
            tick_count_next = tick_inc;
            cmd_next        = CMD_RISE;
          end
        end
        PH_HOLD: begin
          cmd_next = CMD_HOLD;
          // zero hold length: hold forever, counter frozen
          if (cfg.hold_tenths != '0) begin
            tick_count_next = tick_inc;
            if (tick_inc >= hold_limit) begin
              tick_count_next = '0;
              cmd_next        = CMD_LOAD_FALL;
              phase_reg_next  = PH_FALL;
            end
          end
        end
        PH_FALL: begin
          tick_count_next = tick_inc;
          if (tick_inc >= COUNT_WIDTH'(cfg.ramp_down_ticks)) begin
            cmd_next       = CMD_ZERO;
            phase_reg_next = PH_CHAN;
          end else begin
            cmd_next = CMD_FALL;
          end
        end
        PH_CHAN: begin
          advanced_next   = 1'b1;
          tick_count_next = '0;
          if (wrapped && cfg.channel_steps != '0) begin
            channel_count_next = chan_inc;
          end
          if (wrapped && cfg.channel_steps != '0 && chan_inc >= cfg.channel_steps) begin
            phase_reg_next = PH_RELAX;
          end else begin
            cmd_next       = CMD_LOAD_RISE;
            phase_reg_next = PH_RISE;
          end
        end
        default: begin
          // relax
          tick_count_next = tick_inc;
          if (tick_inc >= relax_limit) begin
            if (cfg.cycles_per_bank != '0) begin
              cycle_count_next = cycle_inc;
              if (cycle_inc >= cfg.cycles_per_bank) begin
                bank_reg_next    = ~bank_reg;
                toggled_next     = 1'b1;
                cycle_count_next = '0;
              end
            end
            channel_count_next = '0;
            tick_count_next    = '0;
            cmd_next           = CMD_LOAD_RISE;
            phase_reg_next     = PH_RISE;
          end
        end
      endcase
    end
  end

  // Advance the machine on each accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_OFF;
      tick_count    <= '0;
      channel_count <= '0;
      cycle_count   <= '0;
      bank_reg      <= 1'b0;
    end else if (accept) begin
      phase_reg     <= phase_reg_next;
      tick_count    <= tick_count_next;
      channel_count <= channel_count_next;
      cycle_count   <= cycle_count_next;
      bank_reg      <= bank_reg_next;
    end
  end

  // Result register: hold while stalled, drop valid once the transfer is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_phase    <= phase_reg_next;
      out_cmd      <= cmd_next;
      out_bank     <= bank_reg_next;
      out_toggled  <= toggled_next;
      out_advanced <= advanced_next;
    end
  end

  assign m_tdata = {7'b0, out_advanced, out_toggled, out_bank, out_cmd, out_phase};

  // A bank toggle only ever happens on the way out of relax into ramp up.
  a_toggle_enters_rise: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_toggled) |-> (out_phase == PH_RISE && out_cmd == CMD_LOAD_RISE))
    else $error("bank toggle outside relax exit");

  // A channel advance leaves the machine in ramp up or relax.
  a_advance_target: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_advanced) |-> (out_phase == PH_RISE || out_phase == PH_RELAX))
    else $error("channel advance into wrong phase");

  // Every accepted transfer yields a pending result on the next cycle.
  a_accept_yields_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transfer produced no result");

endmodule
